>>> rtl/gpc_pkg.sv
`timescale 1ns / 1ps
package gpc_pkg;

	localparam int MAX_STOPS = 16;
	localparam int IDX_W     = $clog2(MAX_STOPS);
	localparam int CNT_W     = $clog2(MAX_STOPS + 1);
	localparam int ADDR_W    = IDX_W + 1;
	localparam int DEPTH     = 2 * MAX_STOPS;

	localparam logic [15:0] TRANSITION_RESET = 16'd1000;
	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_STOPS);

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_COMMIT = 2'd1,
		FUNC_SAMPLE = 2'd2,
		FUNC_TICK   = 2'd3
	} func_t;

	typedef enum logic {
		CFG_IS_RGBW       = 1'b0,
		CFG_TRANSITION_MS = 1'b1
	} cfg_idx_t;

	// channel 0 red, 1 green, 2 blue, 3 white
	typedef logic [3:0][7:0] chan_t;

	typedef struct packed {
		logic [7:0] pos;
		chan_t      ch;
	} stop_t;

endpackage

>>> rtl/gradient_palette_crossfade_unit.sv
`timescale 1ns / 1ps
// write, commit and tick words complete in the idle state; a sample scans the stops of a bank and
// interpolates, for the active bank and, during a fade, the pending bank, then blends the two
// the stop scan uses the single read port; interpolation and blend use the 8-step divider
// one item is in work at a time; in_stall is high while a sample is in work
// reset (arst_n low, asynchronous) clears all control state; stop memory is undefined until written
module gradient_palette_crossfade_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  stop_index,
	input  logic [7:0]  stop_position,
	input  logic [7:0]  stop_red,
	input  logic [7:0]  stop_green,
	input  logic [7:0]  stop_blue,
	input  logic [7:0]  stop_white,
	input  logic [4:0]  stop_count,
	input  logic [7:0]  sample_position,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] color,
	output logic        fading,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_SCAN, S_LERP, S_DIV, S_LDONE, S_BANK, S_BLEND, S_PACK
	} state_t;

	localparam int CNT_W_L = gpc_pkg::CNT_W;

	state_t state_q;

	logic        is_rgbw_q;
	logic [15:0] transition_q;
	logic        active_bank_q;
	logic [gpc_pkg::CNT_W-1:0] active_count_q, pending_count_q;
	logic        has_current_q, switch_pending_q;
	logic [15:0] remaining_q;

	gpc_pkg::stop_t mem [gpc_pkg::DEPTH];
	gpc_pkg::stop_t rdata_q;
	logic [gpc_pkg::ADDR_W-1:0] rd_addr;
	logic rd_en;

	logic [7:0]  pos_q;
	logic        bk_q, bank_b_q, blend_q;
	logic [gpc_pkg::CNT_W-1:0] cnt_q;
	logic [gpc_pkg::IDX_W-1:0] rdidx_q;
	gpc_pkg::stop_t first_q, prev_q, s_q, e_q;
	gpc_pkg::chan_t res_q, cha_q;
	logic [3:0]  neg_q;

	logic [3:0][23:0] rem_q;
	logic [3:0][7:0]  quo_q;
	logic [15:0] div_d_q;
	logic [2:0]  bit_q;

	logic [7:0] den, num;
	logic [3:0][23:0] lerp_dvd, blend_dvd;
	logic [3:0] lerp_neg;
	logic [15:0] t_eff, r_eff;
	logic [23:0] d_shift;
	logic [CNT_W_L-1:0] cnt_sat;
	logic accept, cfg_wr;
	logic last_idx, in_seg;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign cfg_wr = cfg_we;

	assign cnt_sat = (stop_count > gpc_pkg::MAX_COUNT) ? gpc_pkg::MAX_COUNT : stop_count;

	// writes land only while idle, reads only while busy: no same-entry overlap
	always_comb begin
		rd_en = 1'b0;
		rd_addr = {bk_q, {gpc_pkg::IDX_W{1'b0}}};
		if (state_q == S_START) begin
			rd_en = 1'b1;
		end else if (state_q == S_SCAN) begin
			rd_en = 1'b1;
			rd_addr = {bk_q, rdidx_q + gpc_pkg::IDX_W'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (gpc_pkg::func_t'(func) == gpc_pkg::FUNC_WRITE) && !switch_pending_q)
			mem[{~active_bank_q, stop_index}] <= {stop_position,
				stop_white, stop_blue, stop_green, stop_red};
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign last_idx = ({1'b0, rdidx_q} == cnt_q - CNT_W_L'(1));
	assign in_seg = (pos_q >= prev_q.pos) && (pos_q <= rdata_q.pos);

	assign den = e_q.pos - s_q.pos;
	assign num = pos_q - s_q.pos;

	always_comb begin
		t_eff = transition_q;
		r_eff = remaining_q;
		if (transition_q == 16'd0) begin
			t_eff = 16'd1;
			r_eff = 16'd0;
		end else if (remaining_q > transition_q) begin
			r_eff = transition_q;
		end
		for (int k = 0; k < 4; k++) begin
			lerp_neg[k] = e_q.ch[k] < s_q.ch[k];
			if (lerp_neg[k])
				lerp_dvd[k] = 24'(num * (s_q.ch[k] - e_q.ch[k])) + 24'(den) - 24'd1;
			else
				lerp_dvd[k] = 24'(num * (e_q.ch[k] - s_q.ch[k]));
			blend_dvd[k] = 24'(cha_q[k] * r_eff) + 24'(res_q[k] * (t_eff - r_eff));
		end
	end

	assign d_shift = {8'd0, div_d_q} << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			is_rgbw_q        <= 1'b0;
			transition_q     <= gpc_pkg::TRANSITION_RESET;
			active_bank_q    <= 1'b0;
			active_count_q   <= '0;
			pending_count_q  <= '0;
			has_current_q    <= 1'b0;
			switch_pending_q <= 1'b0;
			remaining_q      <= '0;
			out_valid        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (gpc_pkg::cfg_idx_t'(cfg_index))
					gpc_pkg::CFG_IS_RGBW:       is_rgbw_q <= cfg_data[0];
					gpc_pkg::CFG_TRANSITION_MS: transition_q <= cfg_data;
				endcase
			end
			if (out_valid && !out_stall && state_q != S_PACK)
				out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (gpc_pkg::func_t'(func))
							gpc_pkg::FUNC_WRITE: ;
							gpc_pkg::FUNC_COMMIT: begin
								if (!switch_pending_q) begin
									pending_count_q  <= cnt_sat;
									switch_pending_q <= 1'b1;
									remaining_q      <= transition_q;
								end
							end
							gpc_pkg::FUNC_TICK: begin
								if (switch_pending_q) begin
									if (elapsed_ms >= remaining_q) begin
										remaining_q      <= '0;
										active_bank_q    <= ~active_bank_q;
										active_count_q   <= pending_count_q;
										has_current_q    <= 1'b1;
										switch_pending_q <= 1'b0;
									end else begin
										remaining_q <= remaining_q - elapsed_ms;
									end
								end
							end
							gpc_pkg::FUNC_SAMPLE: begin
								pos_q    <= sample_position;
								bk_q     <= active_bank_q;
								cnt_q    <= active_count_q;
								bank_b_q <= 1'b0;
								cha_q    <= '0;
								state_q  <= has_current_q ? S_START : S_PACK;
							end
						endcase
					end
				end
				S_START: begin
					rdidx_q <= '0;
					if (cnt_q == '0) begin
						res_q   <= '0;
						state_q <= S_BANK;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rdidx_q <= rdidx_q + gpc_pkg::IDX_W'(1);
					prev_q  <= rdata_q;
					if (rdidx_q == '0) begin
						first_q <= rdata_q;
						if (cnt_q == CNT_W_L'(1)) begin
							res_q   <= rdata_q.ch;
							state_q <= S_BANK;
						end
					end else if (in_seg) begin
						s_q     <= prev_q;
						e_q     <= rdata_q;
						state_q <= S_LERP;
					end else if (last_idx) begin
						// outside the stops: clamp to an end stop
						res_q   <= (pos_q < first_q.pos) ? first_q.ch : rdata_q.ch;
						state_q <= S_BANK;
					end
				end
				S_LERP: begin
					if (den == 8'd0) begin
						res_q   <= s_q.ch;
						state_q <= S_BANK;
					end else begin
						rem_q   <= lerp_dvd;
						neg_q   <= lerp_neg;
						div_d_q <= {8'd0, den};
						quo_q   <= '0;
						bit_q   <= 3'd7;
						blend_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					for (int k = 0; k < 4; k++) begin
						if (rem_q[k] >= d_shift) begin
							rem_q[k]        <= rem_q[k] - d_shift;
							quo_q[k][bit_q] <= 1'b1;
						end
					end
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0)
						state_q <= S_LDONE;
				end
				S_LDONE: begin
					if (blend_q) begin
						cha_q   <= quo_q;
						state_q <= S_PACK;
					end else begin
						for (int k = 0; k < 4; k++)
							res_q[k] <= neg_q[k] ? s_q.ch[k] - quo_q[k] : s_q.ch[k] + quo_q[k];
						state_q <= S_BANK;
					end
				end
				S_BANK: begin
					if (bank_b_q) begin
						state_q <= S_BLEND;
					end else begin
						cha_q <= res_q;
						if (switch_pending_q) begin
							bank_b_q <= 1'b1;
							bk_q     <= ~active_bank_q;
							cnt_q    <= pending_count_q;
							state_q  <= S_START;
						end else begin
							state_q <= S_PACK;
						end
					end
				end
				S_BLEND: begin
					rem_q   <= blend_dvd;
					div_d_q <= t_eff;
					quo_q   <= '0;
					bit_q   <= 3'd7;
					blend_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_PACK: begin
					if (!out_valid || !out_stall) begin
						color     <= {is_rgbw_q ? cha_q[3] : 8'd0, cha_q[0], cha_q[1], cha_q[2]};
						fading    <= switch_pending_q;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
